[rtl/iira_pkg.sv]
// ----------------------------------------------------------------------------
// iira_pkg: shared types and constants for the insert/remove array
// Request and status codes, field widths, the command broadcast to the
// entry cells, and helpers that size the read reduction tree.
// ----------------------------------------------------------------------------
package iira_pkg;

    // Field widths of the stream words.
    localparam int REQ_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 7;
    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd4;
    localparam logic [REQ_W-1:0] REQ_CREATE = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // Fan-in of one node of the read tree.
    localparam int TREE_RADIX = 8;

    // Operation applied by every cell in the same cycle.
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SET,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   data;
    } cell_cmd_t;

    // Radix raised to a power.
    function automatic int radix_pow(input int k);
        int p;
        p = 1;
        for (int m = 0; m < 8; m++) begin
            if (m < k) begin
                p = p * TREE_RADIX;
            end
        end
        return p;
    endfunction

    // Number of registered tree levels needed to cover n leaves.
    function automatic int tree_levels(input int n);
        int l;
        int p;
        l = 1;
        p = TREE_RADIX;
        for (int m = 0; m < 8; m++) begin
            if (p < n) begin
                p = p * TREE_RADIX;
                l = l + 1;
            end
        end
        return l;
    endfunction

    // First node index of level k (levels count from one at the leaves).
    function automatic int level_offset(input int levels, input int k);
        int off;
        off = 0;
        for (int m = 1; m < 8; m++) begin
            if (m < k) begin
                off = off + radix_pow(levels - m);
            end
        end
        return off;
    endfunction

endpackage

[rtl/indexed_insert_remove_array.sv]
// ----------------------------------------------------------------------------
// indexed_insert_remove_array: ordered array with insert and remove
// Keeps up to CAPACITY signed 32-bit entries in a row of cells and serves
// read, write, insert, remove, append and create requests.
// ----------------------------------------------------------------------------
// Usage:
// A request word enters on the s_axis channel and gives exactly one result
// word on the m_axis channel, in order. Write, insert, remove, append, create,
// unknown requests and failed reads finish at the accepting edge: the result
// is valid in the next cycle and the block can take another request in that
// cycle if the receiver is ready, so these run at one word per cycle while
// the receiver keeps up. Insert and remove move every entry above the
// position in the same cycle, one cell to the next. A successful read goes
// through a registered OR tree of fan-in eight with ceil(log8(CAPACITY))
// levels; the tree depth sets the read wait, and no request is taken
// meanwhile.
// s_axis_tready is high only when the block is not reading and the result
// register is empty or being emptied in the same cycle; a stalled receiver
// therefore holds off new requests after one pending result.
// Reset clears every entry to zero, the length to zero and the result valid.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array
    import iira_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Request channel.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: req_type [2:0], position [9:3], data_in [41:10], zero [47:42].
    input  logic [IN_W-1:0]  s_axis_tdata,
    // Result channel.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata: status [1:0], read_data [33:2], length_now [40:34], zero [47:41].
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int SLOT_W = (FILL_W > POS_W) ? FILL_W : POS_W;
    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int CNT_W  = $clog2(LEVELS + 1);

    // Controller states.
    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic                state_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [SLOT_W-1:0]   rd_slot_reg;
    logic                m_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [DATA_W-1:0]   out_rdata_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic [REQ_W-1:0]    in_req;
    logic [POS_W-1:0]    in_position;
    logic [DATA_W-1:0]   in_data;
    logic                accept;
    logic                start_read;
    logic                read_done;
    logic [SLOT_W-1:0]   pos_s;
    logic [SLOT_W-1:0]   fill_s;
    logic [SLOT_W-1:0]   cap_s;
    logic [SLOT_W-1:0]   fill_next_s;
    logic [SLOT_W-1:0]   fill_cur_s;
    logic [STAT_W-1:0]   res_status;
    logic [DATA_W-1:0]   res_rdata;
    cell_cmd_t           cmd_req;
    cell_cmd_t           cmd;
    logic [SLOT_W-1:0]   cmd_slot;
    logic [DATA_W-1:0]   entry   [CAPACITY];
    logic [DATA_W-1:0]   rd_root;

    // Unpack the request word.
    assign in_req      = s_axis_tdata[2:0];
    assign in_position = s_axis_tdata[9:3];
    assign in_data     = s_axis_tdata[41:10];

    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign read_done     = (state_reg == S_READ) && (cnt_reg == CNT_W'(LEVELS));

    // Decode the request: status, immediate result, new length, cell command.
    always_comb begin
        pos_s        = SLOT_W'(in_position);
        fill_s       = SLOT_W'(fill_reg);
        cap_s        = SLOT_W'(CAPACITY);
        res_status   = STATUS_OK;
        res_rdata    = '0;
        fill_next    = fill_reg;
        cmd_req.op   = CMD_HOLD;
        cmd_req.data = in_data;
        cmd_slot     = pos_s;
        start_read   = 1'b0;
        unique case (in_req)
            REQ_READ: begin
                if (pos_s < fill_s) begin
                    start_read = 1'b1;
                end else begin
                    res_status = STATUS_RANGE;
                    res_rdata  = '1;
                end
            end
            REQ_WRITE: begin
                if (pos_s < fill_s) begin
                    cmd_req.op = CMD_SET;
                end else begin
                    res_status = STATUS_RANGE;
                end
            end
            REQ_INSERT: begin
                if (pos_s > fill_s) begin
                    res_status = STATUS_RANGE;
                end else if (fill_s >= cap_s) begin
                    res_status = STATUS_FULL;
                end else begin
                    cmd_req.op = CMD_INSERT;
                    fill_next  = FILL_W'(fill_reg + 1'b1);
                end
            end
            REQ_REMOVE: begin
                if (pos_s >= fill_s) begin
                    res_status = STATUS_RANGE;
                end else begin
                    cmd_req.op = CMD_REMOVE;
                    fill_next  = FILL_W'(fill_reg - 1'b1);
                end
            end
            REQ_APPEND: begin
                if (fill_s >= cap_s) begin
                    res_status = STATUS_FULL;
                end else begin
                    cmd_req.op = CMD_SET;
                    cmd_slot   = fill_s;
                    fill_next  = FILL_W'(fill_reg + 1'b1);
                end
            end
            REQ_CREATE: begin
                if (pos_s > cap_s) begin
                    res_status = STATUS_FULL;
                end else begin
                    cmd_req.op = CMD_CLEAR;
                    fill_next  = FILL_W'(pos_s);
                end
            end
            default: begin
                res_status = STATUS_OK;
            end
        endcase
    end

    // Cells act only on an accepted request.
    always_comb begin
        cmd    = cmd_req;
        if (!accept) begin
            cmd.op = CMD_HOLD;
        end
    end

    assign fill_next_s = SLOT_W'(fill_next);
    assign fill_cur_s  = SLOT_W'(fill_reg);

    // Row of entry cells, each linked to both neighbors.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] lower;
        logic [DATA_W-1:0] upper;
        if (i == 0) begin : g_bottom
            assign lower = '0;
        end else begin : g_lower
            assign lower = entry[i - 1];
        end
        if (i == CAPACITY - 1) begin : g_top
            assign upper = '0;
        end else begin : g_upper
            assign upper = entry[i + 1];
        end
        iira_cell #(
            .INDEX  (i),
            .SLOT_W (SLOT_W)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .slot        (cmd_slot),
            .lower_entry (lower),
            .upper_entry (upper),
            .entry       (entry[i])
        );
    end

    // Read-out tree.
    iira_rdtree #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W)
    ) u_rdtree (
        .aclk    (aclk),
        .rd_slot (rd_slot_reg),
        .entries (entry),
        .root    (rd_root)
    );

    // Control: state, length and read wait counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        fill_reg <= fill_next;
                        if (start_read) begin
                            state_reg <= S_READ;
                            cnt_reg   <= '0;
                        end
                    end
                end
                S_READ: begin
                    if (read_done) begin
                        state_reg   <= S_IDLE;
                    end else begin
                        cnt_reg <= CNT_W'(cnt_reg + 1'b1);
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Result valid: set when a result is loaded, cleared when it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((accept && !start_read) || read_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result word and read position.
    always_ff @(posedge aclk) begin
        if (accept && start_read) begin
            rd_slot_reg <= pos_s;
        end
        if (accept && !start_read) begin
            out_status_reg <= res_status;
            out_rdata_reg  <= res_rdata;
            out_len_reg    <= fill_next_s[LEN_W-1:0];
        end else if (read_done) begin
            out_status_reg <= STATUS_OK;
            out_rdata_reg  <= rd_root;
            out_len_reg    <= fill_cur_s[LEN_W-1:0];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, out_len_reg, out_rdata_reg, out_status_reg};

endmodule

[rtl/iira_cell.sv]
// ----------------------------------------------------------------------------
// iira_cell: one entry of the array
// Holds one entry and, on the broadcast command, keeps it, overwrites it,
// clears it, or takes its lower (insert) or upper (remove) neighbor's entry.
// ----------------------------------------------------------------------------
module iira_cell
    import iira_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int SLOT_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cell_cmd_t         cmd,
    input  logic [SLOT_W-1:0] slot,
    input  logic [DATA_W-1:0] lower_entry,
    input  logic [DATA_W-1:0] upper_entry,
    output logic [DATA_W-1:0] entry
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    // Next value from the broadcast command and this cell's place in the row.
    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.op)
            CMD_SET: begin
                if (MY_SLOT == slot) begin
                    entry_next = cmd.data;
                end
            end
            CMD_INSERT: begin
                if (MY_SLOT > slot) begin
                    entry_next = lower_entry;
                end else if (MY_SLOT == slot) begin
                    entry_next = cmd.data;
                end
            end
            CMD_REMOVE: begin
                if (MY_SLOT >= slot) begin
                    entry_next = upper_entry;
                end
            end
            CMD_CLEAR: begin
                entry_next = '0;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The store resets to all zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

[rtl/iira_rdtree.sv]
// ----------------------------------------------------------------------------
// iira_rdtree: registered read-out tree
// Each leaf passes its entry only when its index matches the read slot; an
// OR tree of fan-in eight, one register per level, delivers the entry.
// ----------------------------------------------------------------------------
module iira_rdtree
    import iira_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int SLOT_W   = 7
) (
    input  logic              aclk,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic [DATA_W-1:0] entries [CAPACITY],
    output logic [DATA_W-1:0] root
);

    localparam int LEVELS = tree_levels(CAPACITY);
    localparam int LEAVES = radix_pow(LEVELS);
    localparam int NODES  = level_offset(LEVELS, LEVELS + 1);

    logic [DATA_W-1:0] leaf     [LEAVES];
    logic [DATA_W-1:0] node_reg [NODES];

    // Leaves: the selected entry, zero elsewhere and in the padding.
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < CAPACITY) begin : g_used
            assign leaf[j] = (rd_slot == SLOT_W'(j)) ? entries[j] : '0;
        end else begin : g_pad
            assign leaf[j] = '0;
        end
    end

    // One registered OR level after another toward the root.
    for (genvar k = 1; k <= LEVELS; k++) begin : g_level
        for (genvar j = 0; j < radix_pow(LEVELS - k); j++) begin : g_node
            if (k == 1) begin : g_first
                always_ff @(posedge aclk) begin
                    logic [DATA_W-1:0] acc;
                    acc = '0;
                    for (int c = 0; c < TREE_RADIX; c++) begin
                        acc = acc | leaf[j * TREE_RADIX + c];
                    end
                    node_reg[level_offset(LEVELS, k) + j] <= acc;
                end
            end else begin : g_upper
                always_ff @(posedge aclk) begin
                    logic [DATA_W-1:0] acc;
                    acc = '0;
                    for (int c = 0; c < TREE_RADIX; c++) begin
                        acc = acc
                            | node_reg[level_offset(LEVELS, k - 1) + j * TREE_RADIX + c];
                    end
                    node_reg[level_offset(LEVELS, k) + j] <= acc;
                end
            end
        end
    end

    assign root = node_reg[NODES - 1];

endmodule
